/* sv/sgc_pkg.sv */
`default_nettype none
package sgc_pkg;

  // Widths fixed by the tick and result formats
  localparam int unsigned KEY_W = 48;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned IN_TDATA_W = 176;
  localparam int unsigned OUT_TDATA_W = 328;

  // Result status codes
  localparam logic [2:0] ST_IN_ORDER    = 3'd0;
  localparam logic [2:0] ST_UNCHECKED   = 3'd1;
  localparam logic [2:0] ST_EPOCH_RESET = 3'd2;
  localparam logic [2:0] ST_GAP         = 3'd3;
  localparam logic [2:0] ST_DUPLICATE   = 3'd4;
  localparam logic [2:0] ST_BACKWARDS   = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd6;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  // Search packet moving along the row of cells (slot indexes travel beside it)
  typedef struct packed {
    logic             active;
    logic             hit;
    logic             free_hit;
    logic [VAL_W-1:0] epoch;
    logic [VAL_W-1:0] last;
    logic [VAL_W-1:0] gaps;
  } scan_pkt_t;

  // Watermark update broadcast to the row (slot index travels beside it)
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] epoch;
    logic [VAL_W-1:0] seq;
    logic [VAL_W-1:0] gaps;
  } entry_wr_t;

endpackage
`default_nettype wire

/* sv/source_sequence_gap_checker_top.sv */
// Per-source sequence gap checker.
//
// Input channel in_*: one market tick per transfer (source key, epoch and
// sequence). Result channel out_*: one verdict per tick, in tick order.
// The table holds MAX_SOURCES source watermarks, one per cell in a row of
// cells. A tick is looked up by sending a search packet down that row, one
// cell per cycle, and out_tvalid rises once the packet has left the last
// cell and the result is registered; the next tick is taken only once the
// result has been written to the output register, so the walk along the
// row of cells sets the rate at which ticks are taken.
// The result is held in an output register until out_tready takes it; a
// stalled receiver holds the block only after the next tick has also been
// searched, at which point in_tready stays low.
// Reset (rst_n low, synchronous) empties the table at once and clears all
// running totals; no sweep is needed before the first tick.
`default_nettype none
module source_sequence_gap_checker_top
  import sgc_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // platform_version[15:0], source_number[47:16], source_epoch[111:48],
  // sequence_req[175:112]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // accepted[0], status[3:1], source_gap_total[67:4], duplicate_total[131:68],
  // backwards_total[195:132], epoch_reset_total[259:196], gap_total[323:260],
  // zero[327:324]
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  logic      [KEY_W-1:0] key;
  entry_wr_t             wr;
  logic      [IDX_W-1:0] wr_idx;

  scan_pkt_t             pkt   [MAX_SOURCES+1];
  logic      [IDX_W-1:0] hit_i [MAX_SOURCES+1];
  logic      [IDX_W-1:0] free_i[MAX_SOURCES+1];

  assign hit_i[0]  = '0;
  assign free_i[0] = '0;

  sgc_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .key           (key),
    .head_pkt      (pkt[0]),
    .tail_pkt      (pkt[MAX_SOURCES]),
    .tail_hit_idx  (hit_i[MAX_SOURCES]),
    .tail_free_idx (free_i[MAX_SOURCES]),
    .wr            (wr),
    .wr_idx        (wr_idx)
  );

  // Row of watermark cells, lowest slot first
  for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_cell
    sgc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .key          (key),
      .pkt_in       (pkt[g]),
      .hit_idx_in   (hit_i[g]),
      .free_idx_in  (free_i[g]),
      .pkt_out      (pkt[g+1]),
      .hit_idx_out  (hit_i[g+1]),
      .free_idx_out (free_i[g+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

endmodule
`default_nettype wire

/* sv/sgc_cell.sv */
`default_nettype none
module sgc_cell
  import sgc_pkg::*;
#(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] key,
  input  wire scan_pkt_t        pkt_in,
  input  wire logic [IDX_W-1:0] hit_idx_in,
  input  wire logic [IDX_W-1:0] free_idx_in,
  output scan_pkt_t             pkt_out,
  output logic      [IDX_W-1:0] hit_idx_out,
  output logic      [IDX_W-1:0] free_idx_out,
  input  wire entry_wr_t        wr,
  input  wire logic [IDX_W-1:0] wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] epoch_r;
  logic [VAL_W-1:0] last_r;
  logic [VAL_W-1:0] gaps_r;

  scan_pkt_t        pkt_r, pkt_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  // Take the search packet: claim a key match, or note the lowest free slot
  always_comb begin
    pkt_nxt      = pkt_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (pkt_in.active) begin
      if (valid_r && !pkt_in.hit && (key_r == key)) begin
        pkt_nxt.hit   = 1'b1;
        pkt_nxt.epoch = epoch_r;
        pkt_nxt.last  = last_r;
        pkt_nxt.gaps  = gaps_r;
        hit_idx_nxt   = MY_IDX;
      end
      if (!valid_r && !pkt_in.free_hit) begin
        pkt_nxt.free_hit = 1'b1;
        free_idx_nxt     = MY_IDX;
      end
    end
  end

  // Pass the packet on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.active <= 1'b0;
    end else begin
      pkt_r.active <= pkt_nxt.active;
    end
    pkt_r.hit      <= pkt_nxt.hit;
    pkt_r.free_hit <= pkt_nxt.free_hit;
    pkt_r.epoch    <= pkt_nxt.epoch;
    pkt_r.last     <= pkt_nxt.last;
    pkt_r.gaps     <= pkt_nxt.gaps;
    hit_idx_r      <= hit_idx_nxt;
    free_idx_r     <= free_idx_nxt;
  end

  assign pkt_out      = pkt_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

  // Hold the entry; write the watermark when this slot is addressed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.en && (wr_idx == MY_IDX)) begin
      valid_r <= 1'b1;
    end
    if (wr.en && (wr_idx == MY_IDX)) begin
      key_r   <= wr.key;
      epoch_r <= wr.epoch;
      last_r  <= wr.seq;
      gaps_r  <= wr.gaps;
    end
  end

endmodule
`default_nettype wire

/* sv/sgc_ctrl.sv */
`default_nettype none
module sgc_ctrl
  import sgc_pkg::*;
#(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [KEY_W-1:0]       key,
  output scan_pkt_t                   head_pkt,
  input  wire scan_pkt_t              tail_pkt,
  input  wire logic [IDX_W-1:0]       tail_hit_idx,
  input  wire logic [IDX_W-1:0]       tail_free_idx,
  output entry_wr_t                   wr,
  output logic      [IDX_W-1:0]       wr_idx
);

  ctrl_state_t state_r, state_nxt;

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] epoch_r;
  logic [VAL_W-1:0] seq_r;

  scan_pkt_t        res_r;
  logic [IDX_W-1:0] res_hit_idx_r;
  logic [IDX_W-1:0] res_free_idx_r;

  logic [VAL_W-1:0] dup_cnt_r, dup_cnt_nxt;
  logic [VAL_W-1:0] back_cnt_r, back_cnt_nxt;
  logic [VAL_W-1:0] ers_cnt_r, ers_cnt_nxt;
  logic [VAL_W-1:0] gap_cnt_r, gap_cnt_nxt;

  logic             out_valid_r;
  logic             out_acc_r;
  logic [2:0]       out_status_r;
  logic [VAL_W-1:0] out_src_gaps_r;

  logic             fire;
  logic             in_xfer;
  logic             accepted;
  logic [2:0]       status;
  logic [VAL_W-1:0] src_gaps;
  logic [VAL_W-1:0] ent_epoch;
  logic [VAL_W-1:0] ent_last;
  logic [VAL_W-1:0] ent_gaps;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign fire      = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Sequence one tick: launch the search, wait for the tail, then decide
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SCAN;
      S_SCAN:   if (tail_pkt.active) state_nxt = S_DONE;
      S_DONE:   if (fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the tick fields for the whole search
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r   <= in_tdata[47:0];
      epoch_r <= in_tdata[111:48];
      seq_r   <= in_tdata[175:112];
    end
  end

  assign key = key_r;

  // Empty packet enters the first cell for one cycle
  always_comb begin
    head_pkt          = '0;
    head_pkt.active   = (state_r == S_LAUNCH);
  end

  // Capture what the row found
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && tail_pkt.active) begin
      res_r          <= tail_pkt;
      res_hit_idx_r  <= tail_hit_idx;
      res_free_idx_r <= tail_free_idx;
    end
  end

  // Classify the tick against the stored watermark
  always_comb begin
    ent_epoch    = res_r.hit ? res_r.epoch : '0;
    ent_last     = res_r.hit ? res_r.last : '0;
    ent_gaps     = res_r.hit ? res_r.gaps : '0;
    accepted     = 1'b1;
    status       = ST_UNCHECKED;
    src_gaps     = ent_gaps;
    dup_cnt_nxt  = dup_cnt_r;
    back_cnt_nxt = back_cnt_r;
    ers_cnt_nxt  = ers_cnt_r;
    gap_cnt_nxt  = gap_cnt_r;
    wr_idx       = res_r.hit ? res_hit_idx_r : res_free_idx_r;
    if (!res_r.hit && !res_r.free_hit) begin
      accepted = 1'b0;
      status   = ST_TABLE_FULL;
      src_gaps = '0;
    end else if ((ent_epoch == epoch_r) && (ent_last != '0)) begin
      priority if (seq_r == ent_last) begin
        accepted    = 1'b0;
        status      = ST_DUPLICATE;
        dup_cnt_nxt = dup_cnt_r + 64'd1;
      end else if (seq_r < ent_last) begin
        accepted     = 1'b0;
        status       = ST_BACKWARDS;
        back_cnt_nxt = back_cnt_r + 64'd1;
      end else if (seq_r != (ent_last + 64'd1)) begin
        status      = ST_GAP;
        gap_cnt_nxt = gap_cnt_r + 64'd1;
        src_gaps    = ent_gaps + 64'd1;
      end else begin
        status = ST_IN_ORDER;
      end
    end else if (ent_epoch != '0) begin
      status      = ST_EPOCH_RESET;
      ers_cnt_nxt = ers_cnt_r + 64'd1;
    end
    wr.en    = fire && accepted;
    wr.key   = key_r;
    wr.epoch = epoch_r;
    wr.seq   = seq_r;
    wr.gaps  = src_gaps;
  end

  // Advance the running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_cnt_r  <= '0;
      back_cnt_r <= '0;
      ers_cnt_r  <= '0;
      gap_cnt_r  <= '0;
    end else if (fire) begin
      dup_cnt_r  <= dup_cnt_nxt;
      back_cnt_r <= back_cnt_nxt;
      ers_cnt_r  <= ers_cnt_nxt;
      gap_cnt_r  <= gap_cnt_nxt;
    end
  end

  // Output register: hold the result until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_acc_r      <= accepted;
      out_status_r   <= status;
      out_src_gaps_r <= src_gaps;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, gap_cnt_r, ers_cnt_r, back_cnt_r, dup_cnt_r,
                       out_src_gaps_r, out_status_r, out_acc_r};

endmodule
`default_nettype wire

/* dv/tb_source_sequence_gap_checker_top.sv */
`timescale 1ns / 100ps
module tb_source_sequence_gap_checker_top;
  import sgc_pkg::*;

  localparam int unsigned N_SOURCES = 64;
  localparam int unsigned TICK_CYCLES = N_SOURCES + 3;
  localparam int unsigned PRINT_CAP = 100;

  // One market tick as it travels on in_tdata, version in the lowest bits
  typedef struct packed {
    logic [VAL_W-1:0] seq;
    logic [VAL_W-1:0] epoch;
    logic [31:0]      number;   // two's complement, compared as raw bits
    logic [15:0]      version;
  } tick_t;

  // One verdict as it travels on out_tdata, accepted in bit 0
  typedef struct packed {
    logic [3:0]       pad;
    logic [VAL_W-1:0] gaps;
    logic [VAL_W-1:0] epoch_resets;
    logic [VAL_W-1:0] backs;
    logic [VAL_W-1:0] dups;
    logic [VAL_W-1:0] src_gaps;
    logic [2:0]       status;
    logic             accepted;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // platform_version[15:0], source_number[47:16], source_epoch[111:48],
  // sequence_req[175:112]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // accepted[0], status[3:1], source_gap_total[67:4], duplicate_total[131:68],
  // backwards_total[195:132], epoch_reset_total[259:196], gap_total[323:260],
  // zero[327:324]
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Watermark table and totals of the predictor
  logic             wm_valid [N_SOURCES];
  logic [KEY_W-1:0] wm_key   [N_SOURCES];
  logic [VAL_W-1:0] wm_epoch [N_SOURCES];
  logic [VAL_W-1:0] wm_last  [N_SOURCES];
  logic [VAL_W-1:0] wm_gaps  [N_SOURCES];
  logic [VAL_W-1:0] dup_count, back_count, reset_count, gap_count;

  verdict_t         pending_verdicts [$];
  logic [KEY_W-1:0] key_pool [$];
  int unsigned      mismatches = 0;
  int unsigned      ticks_sent = 0;
  int unsigned      verdicts_seen = 0;
  int unsigned      status_seen [8];
  bit               sender_idles = 1'b1;
  bit               receiver_idles = 1'b1;
  int unsigned      stall_left = 0;

  source_sequence_gap_checker_top #(
    .MAX_SOURCES(N_SOURCES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial forever #4 clk = ~clk;

  // Give up after far longer than the slowest correct run
  initial begin
    #5_000_000;
    $display("source_sequence_gap_checker_top test failed");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_W-1:0] rand_seq();
    logic [VAL_W-1:0] s;
    s = rand64();
    if (s == '0) s = 64'd1;
    return s;
  endfunction

  function automatic tick_t mk_tick(input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] epoch,
                                    input logic [VAL_W-1:0] seq);
    tick_t t;
    t.version = key[47:32];
    t.number = key[31:0];
    t.epoch = epoch;
    t.seq = seq;
    return t;
  endfunction

  function automatic int find_source(input logic [KEY_W-1:0] key);
    for (int i = 0; i < N_SOURCES; i++)
      if (wm_valid[i] && wm_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int sources_held();
    int n;
    n = 0;
    for (int i = 0; i < N_SOURCES; i++) if (wm_valid[i]) n++;
    return n;
  endfunction

  // Judge one accepted tick against the watermark table and update it
  function automatic verdict_t judge_tick(input tick_t t);
    verdict_t         v;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] last;
    int               slot;
    v = '0;
    v.accepted = 1'b1;
    key = {t.version, t.number};
    slot = find_source(key);
    // Unknown key: claim the lowest free slot with a zeroed watermark
    if (slot < 0) begin
      for (int i = 0; i < N_SOURCES; i++)
        if (!wm_valid[i]) begin
          slot = i;
          break;
        end
      if (slot >= 0) begin
        wm_valid[slot] = 1'b1;
        wm_key[slot] = key;
        wm_epoch[slot] = '0;
        wm_last[slot] = '0;
        wm_gaps[slot] = '0;
      end
    end
    if (slot < 0) begin
      v.accepted = 1'b0;
      v.status = ST_TABLE_FULL;
    end else begin
      last = wm_last[slot];
      if (wm_epoch[slot] == t.epoch && last != '0) begin
        if (t.seq == last) begin
          dup_count = dup_count + 1;
          v.accepted = 1'b0;
          v.status = ST_DUPLICATE;
        end else if (t.seq < last) begin
          back_count = back_count + 1;
          v.accepted = 1'b0;
          v.status = ST_BACKWARDS;
        end else if (t.seq != last + 1) begin
          gap_count = gap_count + 1;
          wm_gaps[slot] = wm_gaps[slot] + 1;
          v.status = ST_GAP;
        end else begin
          v.status = ST_IN_ORDER;
        end
      end else if (wm_epoch[slot] != '0) begin
        reset_count = reset_count + 1;
        v.status = ST_EPOCH_RESET;
      end else begin
        v.status = ST_UNCHECKED;
      end
      if (v.accepted) begin
        wm_epoch[slot] = t.epoch;
        wm_last[slot] = t.seq;
      end
      v.src_gaps = wm_gaps[slot];
    end
    v.dups = dup_count;
    v.backs = back_count;
    v.epoch_resets = reset_count;
    v.gaps = gap_count;
    return v;
  endfunction

  // Build a mostly well-formed next tick for a source, with some breakage
  function automatic tick_t next_on_key(input logic [KEY_W-1:0] key);
    tick_t            t;
    logic [VAL_W-1:0] last;
    int               slot;
    int unsigned      pick;
    slot = find_source(key);
    pick = $urandom_range(99);
    t = mk_tick(key, '0, 64'd1);
    if (slot < 0 || pick < 8) begin
      // Fresh numbering: new source or new epoch
      case ($urandom_range(3))
        0:       t.epoch = '0;
        1:       t.epoch = (slot < 0) ? rand64() : wm_epoch[slot] + 1;
        default: t.epoch = rand64();
      endcase
      t.seq = $urandom_range(1) ? 64'd1 + $urandom_range(20) : rand_seq();
    end else begin
      t.epoch = wm_epoch[slot];
      last = wm_last[slot];
      if (pick < 60 && last != '1)
        t.seq = last + 1;
      else if (pick < 75 && last < 64'hFFFF_FFFF_FFFF_0000)
        t.seq = last + 2 + $urandom_range(1000);
      else if (pick < 87 || last == 64'd1)
        t.seq = last;
      else
        t.seq = 64'd1 + rand64() % (last - 1);
    end
    return t;
  endfunction

  function automatic logic [KEY_W-1:0] unknown_key();
    logic [KEY_W-1:0] key;
    do key = KEY_W'(rand64()); while (find_source(key) >= 0);
    return key;
  endfunction

  // Send one tick, idling first now and then; predict it on its transfer
  task automatic send_tick(input tick_t t);
    if (sender_idles && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      // Sometimes let the gap start only once the block is ready again
      if ($urandom_range(1)) do @(posedge clk); while (!in_tready);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    pending_verdicts = {pending_verdicts, judge_tick(t)};
    ticks_sent++;
  endtask

  task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (receiver_idles && $urandom_range(7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected verdict
  always @(posedge clk) begin : check_results
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      verdicts_seen++;
      status_seen[got.status]++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result with nothing pending", VAL_W'(got.status), '0);
      end else begin
        want = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (got.accepted != want.accepted)
          flag_mismatch("accepted", VAL_W'(got.accepted), VAL_W'(want.accepted));
        if (got.status != want.status)
          flag_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
        if (got.src_gaps != want.src_gaps)
          flag_mismatch("source_gap_total", got.src_gaps, want.src_gaps);
        if (got.dups != want.dups)
          flag_mismatch("duplicate_total", got.dups, want.dups);
        if (got.backs != want.backs)
          flag_mismatch("backwards_total", got.backs, want.backs);
        if (got.epoch_resets != want.epoch_resets)
          flag_mismatch("epoch_reset_total", got.epoch_resets, want.epoch_resets);
        if (got.gaps != want.gaps)
          flag_mismatch("gap_total", got.gaps, want.gaps);
      end
    end
  end

  // Key extremes and every verdict kind but table full on a handful of sources
  task automatic test_directed();
    logic [KEY_W-1:0] ka, kb, kc;
    ka = {16'h0000, 32'h8000_0000};
    kb = {16'hFFFF, 32'h7FFF_FFFF};
    kc = {16'hFFFF, 32'h8000_0000};
    send_tick(mk_tick(ka, '0, 64'd1));    // new source
    send_tick(mk_tick(ka, '0, 64'd2));    // in order
    send_tick(mk_tick(ka, '0, 64'd2));    // duplicate
    send_tick(mk_tick(ka, '0, 64'd1));    // backwards
    send_tick(mk_tick(ka, '0, 64'd10));   // gap
    send_tick(mk_tick(ka, '0, 64'd11));
    // Stored epoch zero meeting another epoch: unchecked, no epoch reset
    send_tick(mk_tick(ka, 64'd5, 64'd3));
    send_tick(mk_tick(ka, 64'd5, 64'd4));
    send_tick(mk_tick(ka, 64'd7, 64'd1)); // epoch reset
    send_tick(mk_tick(kb, '1, '1));
    send_tick(mk_tick(kb, '1, '1));
    send_tick(mk_tick(kb, '1, 64'd1));
    send_tick(mk_tick(kb, '0, 64'd1));    // reset from the largest epoch
    send_tick(mk_tick(kb, '0, '1));       // gap up to the largest sequence
    send_tick(mk_tick(kc, 64'd1, '1 - 1));
    send_tick(mk_tick(kc, 64'd1, '1));
    send_tick(mk_tick({16'h0000, 32'h7FFF_FFFF}, 64'h8000_0000_0000_0000, 64'd1));
    send_tick(mk_tick({16'h0000, 32'hFFFF_FFFF}, 64'd1, 64'd1));
    send_tick(mk_tick({16'hFFFF, 32'h0000_0000}, 64'd1, 64'd5));
    // Rejected tick reports the stored per-source gap count
    send_tick(mk_tick(ka, 64'd7, 64'd3));
    send_tick(mk_tick(ka, 64'd7, 64'd3));
    for (int i = 0; i < N_SOURCES; i++) if (wm_valid[i]) key_pool = {key_pool, wm_key[i]};
  endtask

  // Well-formed streams over a pool of sources, plus noise
  task automatic test_random_streams();
    logic [KEY_W-1:0] key;
    tick_t            t;
    repeat (36) key_pool = {key_pool, unknown_key()};
    for (int n = 0; n < 1300; n++) begin
      // Switch idling on and off in stretches
      if (n % 60 == 0) begin
        sender_idles = ($urandom_range(3) != 0);
        receiver_idles = ($urandom_range(3) != 0);
      end
      key = key_pool[$urandom_range(key_pool.size() - 1)];
      if ($urandom_range(99) < 7)
        t = mk_tick(key, $urandom_range(1) ? rand64() : '0, rand_seq());
      else
        t = next_on_key(key);
      send_tick(t);
    end
  endtask

  // Fill the table, then mix unknown keys with traffic on held sources
  task automatic test_table_full();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    while (sources_held() < N_SOURCES) send_tick(next_on_key(unknown_key()));
    send_tick(mk_tick(unknown_key(), '1, '1));
    repeat (110) begin
      if ($urandom_range(9) < 3)
        send_tick(mk_tick(unknown_key(), rand64(), rand_seq()));
      else
        send_tick(next_on_key(wm_key[$urandom_range(N_SOURCES - 1)]));
    end
  endtask

  initial begin
    for (int i = 0; i < N_SOURCES; i++) begin
      wm_valid[i] = 1'b0;
      wm_epoch[i] = '0;
      wm_last[i] = '0;
      wm_gaps[i] = '0;
    end
    dup_count = '0;
    back_count = '0;
    reset_count = '0;
    gap_count = '0;
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_streams();
    test_table_full();
    in_tvalid <= 1'b0;
    // Drain, then give the block time to show any stray transfer
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TICK_CYCLES + 8) @(posedge clk);
    $display("Ran %0d ticks and checked %0d verdicts over %0d table slots.",
             ticks_sent, verdicts_seen, N_SOURCES);
    $display({"Verdicts: in order %0d, new %0d, epoch reset %0d, gap %0d, ",
              "dup %0d, back %0d, full %0d"},
             status_seen[ST_IN_ORDER], status_seen[ST_UNCHECKED],
             status_seen[ST_EPOCH_RESET], status_seen[ST_GAP], status_seen[ST_DUPLICATE],
             status_seen[ST_BACKWARDS], status_seen[ST_TABLE_FULL]);
    if (mismatches == 0) begin
      $display("source_sequence_gap_checker_top test passed");
    end else begin
      $display("source_sequence_gap_checker_top test failed");
    end
    $finish;
  end

endmodule
